// ----- sv/bfe_pkg.sv -----
// Shared types and constants for the bloom filter engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bfe_pkg;
	localparam int NUM_BITS   = 65536;
	localparam int MAX_PROBES = 16;
	localparam int IDX_W      = $clog2(NUM_BITS);
	localparam int SIZE_W     = IDX_W + 1;
	localparam int PRB_W      = $clog2(MAX_PROBES) + 1;
	localparam int WORD_W     = 32;
	localparam int COL_W      = $clog2(WORD_W);
	localparam int ROWS       = NUM_BITS / WORD_W;
	localparam int ROW_W      = IDX_W - COL_W;
	localparam int HASH_W     = 64;
	localparam int CNT_W      = 32;
	localparam int CFG_W      = 17;

	localparam logic [1:0] REG_BIT_COUNT   = 2'd0;
	localparam logic [1:0] REG_PROBE_COUNT = 2'd1;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [HASH_W-1:0] base;
		logic [HASH_W-1:0] stride;
	} item_t;

	typedef struct packed {
		logic [1:0] count;
		logic       full;
	} front_stat_t;

	typedef struct packed {
		logic clearing;
		logic busy;
	} back_stat_t;
endpackage
`default_nettype wire

// ----- sv/bfe_front.sv -----
// Front end: accepts requests, fixes a zero stride, buffers them in a two-entry queue.
// Depends on bfe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bfe_front import bfe_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          hold,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [127:0]  s_tdata,
	input  wire logic          s_tuser,
	output logic               q_valid,
	output item_t              q_item,
	input  wire logic          q_pop,
	output front_stat_t        stat
);
	item_t      buf_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	item_t      in_item;

	assign s_tready = (count_q != 2'd2) && !hold;
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = buf_q[rd_ptr_q];
	assign stat     = '{count: count_q, full: (count_q == 2'd2)};

	always_comb begin
		in_item.kind   = s_tuser;
		in_item.base   = s_tdata[HASH_W-1:0];
		in_item.stride = s_tdata[2*HASH_W-1:HASH_W];
		if (in_item.stride == '0) begin
			in_item.stride = HASH_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

// ----- sv/bfe_mod.sv -----
// Iterative remainder unit: 64-bit value mod a 17-bit modulus, four bits per cycle.
// Depends on bfe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bfe_mod import bfe_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [HASH_W-1:0] value,
	input  wire logic [SIZE_W-1:0] modulus,
	output logic                   done,
	output logic [SIZE_W-1:0]      result
);
	localparam int STEP = 4;
	localparam int ITER = HASH_W / STEP;

	logic [SIZE_W-1:0]       rem_q;
	logic [HASH_W-1:0]       sh_q;
	logic [$clog2(ITER)-1:0] cnt_q;
	logic                    busy_q, done_q;
	logic [SIZE_W-1:0]       rem_nxt;

	always_comb begin
		logic [SIZE_W:0] t;
		t = '0;
		rem_nxt = rem_q;
		for (int k = 0; k < STEP; k++) begin
			t = {rem_nxt, sh_q[HASH_W-1-k]};
			if (t >= {1'b0, modulus}) t = t - {1'b0, modulus};
			rem_nxt = t[SIZE_W-1:0];
		end
	end

	assign done   = done_q;
	assign result = rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q  <= value;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			sh_q  <= sh_q << STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(ITER))'(ITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- sv/bfe_back.sv -----
// Back end: probe sequencer, bit store with clearing pass, insert counter, output register.
// Depends on bfe_pkg and bfe_mod.
`timescale 1ns / 1ps
`default_nettype none
module bfe_back import bfe_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [SIZE_W-1:0] size,
	input  wire logic [PRB_W-1:0]  probes,
	input  wire logic              q_valid,
	input  wire item_t             q_item,
	output logic                   q_pop,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [39:0]            m_tdata,
	output back_stat_t             stat
);
	typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_START, ST_MODW, ST_READ, ST_CHECK,
		ST_FIN} state_t;

	state_t             state_q;
	logic [WORD_W-1:0]  mem [ROWS];
	logic [WORD_W-1:0]  rd_q;
	logic [ROW_W-1:0]   clr_q;
	logic [IDX_W-1:0]   idx_q;
	logic               kind_q, all_set_q;
	logic [HASH_W-1:0]  sum_q, stride_q;
	logic [PRB_W-1:0]   probe_q;
	logic [CNT_W-1:0]   ctr_q;
	logic               out_valid_q, hit_q;
	logic [CNT_W-1:0]   out_cnt_q;
	logic               mod_start, mod_done;
	logic [SIZE_W-1:0]  mod_res;
	logic               bit_set, mem_wr, last, out_free;

	bfe_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.value   (sum_q),
		.modulus (size),
		.done    (mod_done),
		.result  (mod_res)
	);

	assign mod_start = (state_q == ST_START);
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign bit_set   = rd_q[idx_q[COL_W-1:0]];
	assign mem_wr    = (state_q == ST_CHECK) && !bit_set && (kind_q == KIND_INSERT);
	assign last      = (probe_q + 1'b1 == probes) || (!bit_set && kind_q == KIND_QUERY);
	assign out_free  = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {7'd0, out_cnt_q, hit_q};
	assign stat      = '{clearing: (state_q == ST_CLEAR), busy: (state_q != ST_IDLE)};

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			mem[clr_q] <= '0;
		end else if (mem_wr) begin
			mem[idx_q[IDX_W-1:COL_W]] <= rd_q | (WORD_W'(1) << idx_q[COL_W-1:0]);
		end
		if (state_q == ST_READ) begin
			rd_q <= mem[idx_q[IDX_W-1:COL_W]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			ctr_q       <= '0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			out_cnt_q   <= '0;
			idx_q       <= '0;
			kind_q      <= KIND_INSERT;
			all_set_q   <= 1'b1;
			sum_q       <= '0;
			stride_q    <= '0;
			probe_q     <= '0;
		end else begin
			if (out_valid_q && m_tready && state_q != ST_FIN) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ROW_W'(ROWS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_valid) begin
						kind_q    <= q_item.kind;
						sum_q     <= q_item.base;
						stride_q  <= q_item.stride;
						probe_q   <= '0;
						all_set_q <= 1'b1;
						state_q   <= ST_START;
					end
				end
				ST_START: state_q <= ST_MODW;
				ST_MODW: begin
					if (mod_done) begin
						idx_q   <= mod_res[IDX_W-1:0];
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (!bit_set) all_set_q <= 1'b0;
					if (last) begin
						state_q <= ST_FIN;
					end else begin
						probe_q <= probe_q + 1'b1;
						sum_q   <= sum_q + stride_q;
						state_q <= ST_START;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						hit_q       <= all_set_q;
						if (kind_q == KIND_INSERT && !all_set_q && ctr_q != '1) begin
							ctr_q     <= ctr_q + 1'b1;
							out_cnt_q <= ctr_q + 1'b1;
						end else begin
							out_cnt_q <= ctr_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- sv/bloom_filter_engine.sv -----
// Bloom filter engine with double hashing, top level: configuration registers,
// front queue and probe back end. Depends on bfe_pkg, bfe_front, bfe_back.
//
// Each request is an insert or a query of a key given as two 64-bit hashes; each
// returns one result (hit, insert count). After reset the bit store is cleared one
// 32-bit row per cycle, all 2048 rows, during which no request is taken. A request
// then runs its probes one after another: each probe runs one 64-bit remainder
// through the shared four-bit-per-cycle modulo unit and one read of the single-port bit
// store, written back when an insert sets a bit. A query stops at its first clear bit.
`timescale 1ns / 1ps
`default_nettype none
module bloom_filter_engine import bfe_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [127:0]     s_tdata,   // first_hash, second_hash
	input  wire logic             s_tuser,   // kind
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [39:0]           m_tdata    // hit, insert count, zero pad
);
	logic [16:0]       bit_count_q;
	logic [4:0]        probe_count_q;
	logic [SIZE_W-1:0] size;
	logic [PRB_W-1:0]  probes;
	logic              q_valid, q_pop;
	item_t             q_item;
	front_stat_t       fstat;
	back_stat_t        bstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q   <= 17'd65536;
			probe_count_q <= 5'd7;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BIT_COUNT:   bit_count_q   <= cfg_data[16:0];
				REG_PROBE_COUNT: probe_count_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (bit_count_q == '0) size = SIZE_W'(1);
		else if (bit_count_q > 17'(NUM_BITS)) size = SIZE_W'(NUM_BITS);
		else size = SIZE_W'(bit_count_q);
		if (probe_count_q == '0) probes = PRB_W'(1);
		else if (probe_count_q > 5'(MAX_PROBES)) probes = PRB_W'(MAX_PROBES);
		else probes = PRB_W'(probe_count_q);
	end

	bfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.hold     (bstat.clearing),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.stat     (fstat)
	);

	bfe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.size     (size),
		.probes   (probes),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.stat     (bstat)
	);

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.clearing |-> !s_tready) else $error("request taken during clear");
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fstat.count != 2'd3) else $error("queue overflow");
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		fstat.full |-> !s_tready) else $error("full queue takes request");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !bstat.busy && q_valid) else $error("bad pop");
endmodule
`default_nettype wire

// ----- bench/tb_bloom_filter_engine.sv -----
// Self-checking testbench for bloom_filter_engine: directed table, then random phases.
// A local double-hashing model predicts each result that the table does not give. Depends on bfe_pkg and the RTL.
`timescale 1ns / 1ps
module tb_bloom_filter_engine;
	import bfe_pkg::*;

	localparam logic [1:0] REG_SPARE_LO = 2'd2;
	localparam logic [1:0] REG_SPARE_HI = 2'd3;

	typedef struct {
		logic        kind;
		bit   [63:0] first_hash;
		bit   [63:0] second_hash;
		bit          typed;
		bit          hit;
		bit   [31:0] key_total;
	} request_row_t;

	typedef struct {
		bit        hit;
		bit [31:0] key_total;
	} lookup_result_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             s_tvalid;
	logic             s_tready;
	logic [127:0]     s_tdata;   // first_hash, second_hash
	logic             s_tuser;   // kind
	logic             m_tvalid;
	logic             m_tready;
	logic [39:0]      m_tdata;   // hit, insert count, zero pad

	bit             filter_bits [NUM_BITS];
	bit [31:0]      added_count;
	bit [16:0]      size_reg;
	bit [4:0]       probes_reg;
	lookup_result_t pending_results [$];
	bit [63:0]      key_pool [$];
	int             fail_count;
	int             send_idle_pct;
	int             recv_stall_pct;

	bloom_filter_engine i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic lookup_result_t probe_filter(logic kind, bit [63:0] base, bit [63:0] stride);
		lookup_result_t res;
		bit [63:0] size;
		bit [63:0] probes;
		bit [63:0] idx;
		bit        all_set;
		all_set = 1'b1;
		size = (size_reg == 0) ? 64'd1 : (size_reg > NUM_BITS) ? 64'(NUM_BITS) : 64'(size_reg);
		probes = (probes_reg == 0) ? 64'd1 :
			(probes_reg > MAX_PROBES) ? 64'(MAX_PROBES) : 64'(probes_reg);
		if (stride == 0)
			stride = 64'd1;
		for (bit [63:0] i = 0; i < probes; i++) begin
			idx = (base + i * stride) % size;
			if (!filter_bits[idx]) begin
				all_set = 1'b0;
				if (kind == KIND_INSERT)
					filter_bits[idx] = 1'b1;
				else
					break;
			end
		end
		if (kind == KIND_INSERT && !all_set && added_count != 32'hFFFF_FFFF)
			added_count++;
		res.hit = all_set;
		res.key_total = added_count;
		return res;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, 0);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[0] !== want.hit)
					report_mismatch("hit", m_tdata[0], want.hit);
				if (m_tdata[32:1] !== want.key_total)
					report_mismatch("key_total", m_tdata[32:1], want.key_total);
				if (m_tdata[39:33] !== 7'd0)
					report_mismatch("pad", m_tdata[39:33], 0);
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic write_register(logic [1:0] index, bit [16:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == REG_BIT_COUNT)
			size_reg = value;
		else if (index == REG_PROBE_COUNT)
			probes_reg = value[4:0];
	endtask

	task automatic drain;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_request(request_row_t row);
		lookup_result_t res;
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= row.kind;
		s_tdata <= {row.second_hash, row.first_hash};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		res = probe_filter(row.kind, row.first_hash, row.second_hash);
		if (row.typed) begin
			res.hit = row.hit;
			res.key_total = row.key_total;
		end
		pending_results.push_back(res);
	endtask

	task automatic random_phase(bit [16:0] size, bit [4:0] probes, int mode, int count);
		request_row_t row;
		bit [63:0] h1;
		bit [63:0] h2;
		drain();
		write_register(REG_BIT_COUNT, size);
		write_register(REG_PROBE_COUNT, probes);
		send_idle_pct  = (mode == 1) ? 54 : (mode == 3) ? 30 : 0;
		recv_stall_pct = (mode == 2) ? 54 : (mode == 3) ? 30 : 0;
		for (int n = 0; n < count; n++) begin
			if (key_pool.size() > 1 && $urandom_range(99) < 45) begin
				h1 = key_pool[$urandom_range(key_pool.size() / 2 - 1) * 2];
				h2 = key_pool[$urandom_range(key_pool.size() / 2 - 1) * 2 + 1];
			end else begin
				h1 = {$urandom, $urandom};
				h2 = {$urandom, $urandom};
				case ($urandom_range(7))
					0: h2 = 64'd0;
					1: h1 = 64'($urandom_range(255));
					2: h2 = 64'hFFFF_FFFF_FFFF_FFFF;
					default: ;
				endcase
				if (key_pool.size() < 400) begin
					key_pool.push_back(h1);
					key_pool.push_back(h2);
				end
			end
			row.kind = $urandom_range(1) ? KIND_QUERY : KIND_INSERT;
			row.first_hash = h1;
			row.second_hash = h2;
			row.typed = 1'b0;
			send_request(row);
		end
		s_tvalid <= 1'b0;
	endtask

	request_row_t directed [] = '{
		'{KIND_QUERY,  64'h0, 64'h0, 1, 0, 32'd0},
		'{KIND_INSERT, 64'h0, 64'h0, 1, 0, 32'd1},
		'{KIND_INSERT, 64'h0, 64'h0, 1, 1, 32'd1},
		'{KIND_QUERY,  64'h0, 64'h0, 1, 1, 32'd1},
		'{KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 32'd2},
		'{KIND_QUERY,  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 32'd2},
		'{KIND_QUERY,  64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 32'd0},
		'{KIND_INSERT, 64'h1, 64'h0, 0, 0, 32'd0},
		'{KIND_QUERY,  64'h3, 64'h1, 0, 0, 32'd0},
		'{KIND_INSERT, 64'h8000_0000_0000_0000, 64'h1_0000, 0, 0, 32'd0},
		'{KIND_QUERY,  64'h8000_0000_0000_0000, 64'h1_0000, 0, 0, 32'd0},
		'{KIND_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 32'd0},
		'{KIND_QUERY,  64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 0, 0, 32'd0},
		'{KIND_QUERY,  64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 32'd0}
	};

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BIT_COUNT;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_INSERT;
		m_tready = 1'b0;
		fail_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		added_count = 0;
		size_reg = 17'd65536;
		probes_reg = 5'd7;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[k])
			send_request(directed[k]);
		s_tvalid <= 1'b0;
		drain();
		write_register(REG_SPARE_LO, 17'h1FFFF);
		write_register(REG_SPARE_HI, 17'h00001);

		random_phase(17'd1, 5'd16, 0, 20);
		random_phase(17'd0, 5'd0, 1, 20);
		random_phase(17'd8, 5'd3, 2, 80);
		random_phase(17'h1FFFF, 5'd31, 3, 100);
		random_phase(17'd65536, 5'd1, 0, 200);
		random_phase(17'd100, 5'd4, 1, 150);
		random_phase(17'd1000, 5'd8, 2, 150);
		random_phase(17'd4096, 5'd16, 3, 100);
		random_phase(17'd65535, 5'd2, 0, 150);
		random_phase(17'd37, 5'd5, 3, 150);
		random_phase(17'd65536, 5'd7, 2, 80);
		drain();

		if (fail_count == 0)
			$display("bloom_filter_engine verification clean");
		else
			$display("bloom_filter_engine verification failed");
		$finish;
	end

	initial begin
		#50ms;
		$display("bloom_filter_engine verification failed");
		$finish;
	end
endmodule
